// ----- sv/simon_pkg.sv -----
// ----------------------------------------------------------------------------
// simon_pkg: shared types and constants for the Simon 32/64 cipher unit
// Word width, round-key index width, the z0 constant sequence, the key
// store write bundle and the sequencer states.
// ----------------------------------------------------------------------------
package simon_pkg;

  localparam int WORD_W   = 16;
  localparam int RK_IDX_W = 6;    // round index width, enough for 62 rounds
  localparam int KEY_WORDS = 4;

  // Schedule constant 2^16 - 4
  localparam logic [WORD_W-1:0] SCHED_CONST = 16'hFFFC;

  // One period of z0, bit j holds sequence element j
  localparam logic [30:0] Z0_PERIOD = 31'b0110011100001101010010001011111;
  localparam logic [61:0] Z0_SEQ    = {Z0_PERIOD, Z0_PERIOD};

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                we;
    logic [RK_IDX_W-1:0] addr;
    logic [WORD_W-1:0]   data;
  } rk_wr_t;

endpackage

// ----- sv/simon32_64_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// simon32_64_block_cipher_unit: Simon 32/64 encrypt/decrypt engine
// Iterative core: one shared round unit, a round-key memory and a small
// sequencer that runs one Feistel round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we writes cfg_wdata into key word cfg_index (0..3).
//   Every key write restarts the key schedule, which fills the round-key
//   memory; in_tready stays low until it is done.
//   Reset clears the key to all zeros and runs the same schedule sweep
//   before the first beat is taken.
//   Input beat: in_tuser is the command (0 encrypt, 1 decrypt), in_tdata
//   carries the two block words. The core then fetches the first round
//   key, runs the rounds one per cycle through the shared round unit and
//   loads the output register; a new beat is taken only once the result
//   is in the output register and the core is idle again.
//   Output beat: out_tdata holds the two result words. The result waits
//   in the output register while out_tready is low; the core meanwhile
//   takes and processes the next beat and holds that result in the round
//   registers until the output register frees up.
// ----------------------------------------------------------------------------
module simon32_64_block_cipher_unit #(
  parameter int ROUND_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] block_word_0, [31:16] block_word_1
  input  logic        in_tuser,   // [0] command
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] out_word_0, [31:16] out_word_1
);
  import simon_pkg::*;

  localparam logic [RK_IDX_W-1:0] LAST_IDX = RK_IDX_W'(ROUND_COUNT - 1);

  rk_wr_t              rk_wr;
  logic                exp_busy;
  logic                rd_en;
  logic [RK_IDX_W-1:0] rd_idx;
  logic [RK_IDX_W-1:0] rd_addr;
  logic [WORD_W-1:0]   rk_data;

  state_t              state_r, state_nxt;
  logic [RK_IDX_W-1:0] rnd_r, rnd_nxt;
  cmd_t                cmd_r;
  logic [WORD_W-1:0]   a_r, b_r;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_data_r;

  logic [WORD_W-1:0]   ru_x, ru_y, ru_z;
  logic                in_fire;
  logic                out_free;

  simon_key_exp #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_key_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .rk_wr     (rk_wr),
    .busy      (exp_busy)
  );

  simon_key_store #(
    .ROUND_COUNT (ROUND_COUNT)
  ) u_key_store (
    .clk     (clk),
    .rk_wr   (rk_wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rk_data)
  );

  // Encrypt: a <- b ^ f(a) ^ k, b <- a. Decrypt mirrors it on b.
  assign ru_x = (cmd_r == CMD_DECRYPT) ? b_r : a_r;
  assign ru_y = (cmd_r == CMD_DECRYPT) ? a_r : b_r;

  simon_round_unit u_round (
    .x (ru_x),
    .y (ru_y),
    .k (rk_data),
    .z (ru_z)
  );

  assign in_tready = (state_r == ST_IDLE) && !exp_busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Fetch the key for the next round in the cycle before it is needed; decrypt walks backward.
  assign rd_idx  = (state_r == ST_LOAD) ? '0 : rnd_r + 1'b1;
  assign rd_addr = (cmd_r == CMD_DECRYPT) ? LAST_IDX - rd_idx : rd_idx;
  assign rd_en   = (state_r == ST_LOAD) || ((state_r == ST_ROUND) && (rnd_r != LAST_IDX));

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        rnd_nxt   = '0;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == LAST_IDX) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold the result until the output register can take it
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= cmd_t'(in_tuser);
      a_r   <= in_tdata[15:0];
      b_r   <= in_tdata[31:16];
    end else if (state_r == ST_ROUND) begin
      if (cmd_r == CMD_DECRYPT) begin
        a_r <= b_r;
        b_r <= ru_z;
      end else begin
        a_r <= ru_z;
        b_r <= a_r;
      end
    end
    if ((state_r == ST_DONE) && out_free) begin
      out_data_r <= {b_r, a_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- sv/simon_round_unit.sv -----
// ----------------------------------------------------------------------------
// simon_round_unit: one Simon Feistel round function
// Returns y ^ f(x) ^ k with f(x) = (x <<< 1 & x <<< 8) ^ (x <<< 2).
// ----------------------------------------------------------------------------
module simon_round_unit (
  input  logic [simon_pkg::WORD_W-1:0] x,
  input  logic [simon_pkg::WORD_W-1:0] y,
  input  logic [simon_pkg::WORD_W-1:0] k,
  output logic [simon_pkg::WORD_W-1:0] z
);
  import simon_pkg::*;

  logic [WORD_W-1:0] rot1;
  logic [WORD_W-1:0] rot2;
  logic [WORD_W-1:0] rot8;

  assign rot1 = {x[14:0], x[15]};
  assign rot2 = {x[13:0], x[15:14]};
  assign rot8 = {x[7:0], x[15:8]};
  assign z    = y ^ ((rot1 & rot8) ^ rot2) ^ k;

endmodule

// ----- sv/simon_key_exp.sv -----
// ----------------------------------------------------------------------------
// simon_key_exp: key registers and key schedule sequencer
// Holds the four key words and, after reset or any key write, sweeps the
// round-key store one entry per cycle using a four-word history window.
// ----------------------------------------------------------------------------
module simon_key_exp #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [simon_pkg::WORD_W-1:0]   cfg_wdata,
  output simon_pkg::rk_wr_t              rk_wr,
  output logic                           busy
);
  import simon_pkg::*;

  localparam logic [RK_IDX_W-1:0] LAST_IDX = RK_IDX_W'(ROUND_COUNT - 1);

  logic [WORD_W-1:0]   key_r  [KEY_WORDS];
  logic [WORD_W-1:0]   win_r  [KEY_WORDS];   // k[i-1], k[i-2], k[i-3], k[i-4]
  logic [RK_IDX_W-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;

  logic [RK_IDX_W-1:0] z_idx;
  logic [WORD_W-1:0]   t0;
  logic [WORD_W-1:0]   t1;
  logic [WORD_W-1:0]   sched_val;
  logic [WORD_W-1:0]   new_key;

  assign z_idx     = cnt_r - RK_IDX_W'(KEY_WORDS);
  assign t0        = {win_r[0][2:0], win_r[0][15:3]} ^ win_r[2];
  assign t1        = t0 ^ {t0[0], t0[15:1]};
  assign sched_val = win_r[3] ^ {{(WORD_W-1){1'b0}}, Z0_SEQ[z_idx]} ^ t1 ^ SCHED_CONST;
  assign new_key   = (cnt_r < RK_IDX_W'(KEY_WORDS)) ? key_r[cnt_r[1:0]] : sched_val;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (cfg_we) begin
      // restart the sweep so the store follows the new key
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      for (int i = 0; i < KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) begin
        key_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  // history window, payload only
  always_ff @(posedge clk) begin
    if (busy_r && !cfg_we) begin
      win_r[0] <= new_key;
      win_r[1] <= win_r[0];
      win_r[2] <= win_r[1];
      win_r[3] <= win_r[2];
    end
  end

  assign rk_wr.we   = busy_r && !cfg_we;
  assign rk_wr.addr = cnt_r;
  assign rk_wr.data = new_key;
  assign busy       = busy_r;

endmodule

// ----- sv/simon_key_store.sv -----
// ----------------------------------------------------------------------------
// simon_key_store: round-key memory
// One write port from the key schedule, one registered read port for the
// round sequencer.
// ----------------------------------------------------------------------------
module simon_key_store #(
  parameter int ROUND_COUNT = 32
) (
  input  logic                               clk,
  input  simon_pkg::rk_wr_t                  rk_wr,
  input  logic                               rd_en,
  input  logic [simon_pkg::RK_IDX_W-1:0]     rd_addr,
  output logic [simon_pkg::WORD_W-1:0]       rd_data
);
  import simon_pkg::*;

  localparam int AW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;

  logic [WORD_W-1:0] mem [ROUND_COUNT];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rk_wr.we) begin
      mem[rk_wr.addr[AW-1:0]] <= rk_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: Simon 32/64 cipher unit, self-checking stream test
// Drives encrypt and decrypt beats through the unit under several keys. A
// software copy of the key schedule and the Feistel rounds predicts every
// result, and a scoreboard compares the results in order. Both stream sides
// idle at random, and the output side sometimes holds off long enough to
// back the unit up into its input.
// ----------------------------------------------------------------------------
module testbench;
  import simon_pkg::*;

  localparam int ROUND_COUNT = 32;
  localparam int MAX_GAP     = 12;
  localparam int HOLD_CYCLES = 300;   // long output hold-off, fills the unit
  localparam int PHASE_ITEMS = 128;

  typedef struct packed {
    logic [15:0] w1;
    logic [15:0] w0;
  } cipher_block_t;

  // Key expansion and round predictor plus the queue of blocks still owed.
  class simon_ledger;
    localparam int ROUNDS = 32;
    // z0 sequence, element 0 first
    localparam bit [0:30] Z0_BITS = 31'b1111101000100101011000011100110;
    localparam logic [15:0] KS_CONST = 16'hFFFC;

    logic [15:0]   key_words [4];
    logic [15:0]   round_key [ROUNDS];
    cipher_block_t owed_blocks [$];
    int            errors;

    function new();
      for (int i = 0; i < 4; i++) key_words[i] = 16'h0000;
      errors = 0;
      expand_schedule();
    endfunction

    function logic [15:0] rol16(logic [15:0] v, int r);
      return (v << r) | (v >> (16 - r));
    endfunction

    function logic [15:0] mix(logic [15:0] x);
      return (rol16(x, 1) & rol16(x, 8)) ^ rol16(x, 2);
    endfunction

    function void expand_schedule();
      logic [15:0] t;
      for (int i = 0; i < 4; i++) round_key[i] = key_words[i];
      for (int i = 4; i < ROUNDS; i++) begin
        t = rol16(round_key[i-1], 13) ^ round_key[i-3];
        t = t ^ rol16(t, 15);
        round_key[i] = round_key[i-4] ^ {15'b0, Z0_BITS[(i-4) % 31]} ^ t ^ KS_CONST;
      end
    endfunction

    function void set_key_word(int idx, logic [15:0] val);
      key_words[idx] = val;
      expand_schedule();
    endfunction

    function cipher_block_t run_rounds(cmd_t cmd, logic [15:0] x, logic [15:0] y);
      cipher_block_t r;
      logic [15:0] t;
      for (int i = 0; i < ROUNDS; i++) begin
        if (cmd == CMD_ENCRYPT) begin
          t = x;
          x = y ^ mix(x) ^ round_key[i];
          y = t;
        end else begin
          t = y;
          y = x ^ mix(y) ^ round_key[ROUNDS-1-i];
          x = t;
        end
      end
      r.w0 = x;
      r.w1 = y;
      return r;
    endfunction

    function void note_block(cmd_t cmd, logic [15:0] x, logic [15:0] y);
      owed_blocks.push_back(run_rounds(cmd, x, y));
    endfunction

    function void check_block(logic [15:0] w0, logic [15:0] w1);
      cipher_block_t exp_blk;
      if (owed_blocks.size() == 0) begin
        $error("result beat %h_%h arrived with nothing expected", w1, w0);
        errors++;
        return;
      end
      exp_blk = owed_blocks.pop_front();
      if (w0 !== exp_blk.w0) begin
        $error("out_word_0: expected %h, got %h", exp_blk.w0, w0);
        errors++;
      end
      if (w1 !== exp_blk.w1) begin
        $error("out_word_1: expected %h, got %h", exp_blk.w1, w1);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed_blocks.size();
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = 2'd0;
  logic [15:0] cfg_wdata  = 16'h0000;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = 32'h0;   // [15:0] block_word_0, [31:16] block_word_1
  logic        in_tuser   = 1'b0;    // [0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;            // [15:0] out_word_0, [31:16] out_word_1

  simon_ledger ledger = new();

  // Random idling: each side flips between idle-prone and back-to-back runs.
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  bit hold_off_req = 1'b0;   // raised by the stimulus, consumed by the receiver

  simon32_64_block_cipher_unit #(.ROUND_COUNT(ROUND_COUNT)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int next_gap(bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Bias block words toward the all-zero and all-one extremes.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one beat and hold it until taken. Valid stays high on exit, so a
  // zero gap on the next beat keeps the stream continuous.
  task automatic send_block(cmd_t cmd, logic [15:0] w0, logic [15:0] w1);
    int gap;
    if ($urandom_range(0, 9) == 0) send_steady = !send_steady;
    gap = next_gap(send_steady);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {w1, w0};
    do @(posedge clk); while (!in_tready);
    ledger.note_block(cmd, w0, w1);
  endtask

  // Write the key words selected by 'which', one per cycle, back to back.
  task automatic program_key(logic [3:0] which, logic [15:0] k0, logic [15:0] k1,
                             logic [15:0] k2, logic [15:0] k3);
    logic [15:0] kw [4];
    kw = '{k0, k1, k2, k3};
    for (int i = 0; i < 4; i++) begin
      if (which[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= 2'(i);
        cfg_wdata <= kw[i];
        @(posedge clk);
        ledger.set_key_word(i, kw[i]);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // Drop valid, drain every owed result, then let the core wind down.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (ROUND_COUNT + 4) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    cmd_t cmd;
    for (int n = 0; n < count; n++) begin
      cmd = cmd_t'($urandom_range(0, 1));
      send_block(cmd, pick_word(), pick_word());
    end
  endtask

  // Result side: random ready gaps, one long hold-off on request.
  initial begin
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 9) == 0) recv_steady = !recv_steady;
      gap = next_gap(recv_steady);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      ledger.check_block(out_tdata[15:0], out_tdata[31:16]);
    end
  end

  // Stimulus: reset, directed beats, then random phases under several keys.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // All-zero key from reset; the unit sweeps the schedule before taking beats.
    send_block(CMD_ENCRYPT, 16'h0000, 16'h0000);
    send_block(CMD_DECRYPT, 16'h0000, 16'h0000);
    send_block(CMD_ENCRYPT, 16'hFFFF, 16'hFFFF);
    send_block(CMD_DECRYPT, 16'hFFFF, 16'hFFFF);
    send_block(CMD_ENCRYPT, 16'hFFFF, 16'h0000);
    send_block(CMD_DECRYPT, 16'h0000, 16'hFFFF);
    drain();

    // Published test key: 6565 6877 encrypts to c69b e9bb.
    program_key(4'b1111, 16'h0100, 16'h0908, 16'h1110, 16'h1918);
    send_block(CMD_ENCRYPT, 16'h6565, 16'h6877);
    send_block(CMD_DECRYPT, 16'hC69B, 16'hE9BB);
    send_block(CMD_ENCRYPT, 16'h0001, 16'h8000);
    send_block(CMD_DECRYPT, 16'h8000, 16'h0001);
    drain();

    // All-ones key.
    program_key(4'b1111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_block(CMD_ENCRYPT, 16'h0000, 16'h0000);
    send_block(CMD_DECRYPT, 16'hFFFF, 16'hFFFF);
    send_block(CMD_ENCRYPT, 16'h5555, 16'hAAAA);
    send_block(CMD_DECRYPT, 16'hAAAA, 16'h5555);
    drain();

    // Random phases; the first and fourth start with a long output hold-off.
    program_key(4'b1111, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    hold_off_req = 1'b1;
    random_phase(PHASE_ITEMS);
    drain();

    program_key(4'b1111, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_phase(PHASE_ITEMS);
    drain();

    program_key(4'b1111, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(PHASE_ITEMS);
    drain();

    // Change one key word only; the rest of the key must carry over.
    program_key(4'b0100, 16'h0, 16'h0, 16'($urandom), 16'h0);
    hold_off_req = 1'b1;
    random_phase(PHASE_ITEMS);
    drain();

    program_key(4'b1111, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    random_phase(PHASE_ITEMS);
    drain();

    program_key(4'b1111, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    random_phase(PHASE_ITEMS);
    drain();

    // drain() already waited out the core latency; any stray beat shows up as
    // an error in the scoreboard.
    if (ledger.errors == 0 && ledger.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/simon_pkg.sv
sv/simon_round_unit.sv
sv/simon_key_exp.sv
sv/simon_key_store.sv
sv/simon32_64_block_cipher_unit.sv
bench/testbench.sv
